>>> rtl/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types and constants of the flow pulse totaliser: field widths,
// command codes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package fpt_pkg;

	// channel count and channel addressing
	localparam int CHANNELS = 4;
	localparam int CH_W     = 2;
	localparam int CH_SLOTS = 1 << CH_W;

	// field widths
	localparam int CMD_W   = 3;
	localparam int CNT_W   = 32;
	localparam int CAL_W   = 12;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 32;

	// volume = floor(pulses * VOL_NUM / (DEN_MUL * factor))
	localparam int VOL_NUM = 800;
	localparam int DEN_MUL = 3;
	localparam int NUM_W   = CNT_W + 10;     // 800 < 2^10
	localparam int DEN_W   = CAL_W + 2;      // 3 < 2^2
	localparam int DIV_STEPS = NUM_W;        // one quotient bit per step
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// reset values of the configuration registers
	localparam logic [CAL_W-1:0] CAL_RESET   = CAL_W'(120);
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_CAL_BASE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BASE = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_END        = CFG_IDX_W'(8);

	// command codes; 5..7 act as query
	localparam logic [CMD_W-1:0] CMD_PULSE = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_TICK  = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_CLEAR = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_MARK  = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_QUERY = CMD_W'(4);

	// controller -> datapath
	typedef struct packed {
		logic item_load;   // latch the incoming beat
		logic apply;       // update channel state / clock
		logic mul_load;    // form numerator and divisor, seed divider
		logic div_step;    // one restoring division step
		logic vol_write;   // store the saturated quotient
		logic out_load;    // capture the status result
	} fpt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic vol_needed;  // item is a pulse on a present channel
	} fpt_stat_t;

endpackage

`default_nettype wire

>>> rtl/fpt_ctrl.sv
// ----------------------------------------------------------------------------
// fpt_ctrl
// Sequencer: accepts one item, steps the datapath through update, divide (pulses
// only) and result capture, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output fpt_pkg::fpt_cmd_t       ctl,
	input  wire fpt_pkg::fpt_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_APPLY,
		S_MUL,
		S_DIV,
		S_WRITE,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [fpt_pkg::DIV_CNT_W-1:0]   step_q;
	logic                            out_valid_q;
	logic                            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl           = '0;
		ctl.item_load = (state_q == S_IDLE) && in_valid;
		ctl.apply     = (state_q == S_APPLY);
		ctl.mul_load  = (state_q == S_MUL);
		ctl.div_step  = (state_q == S_DIV);
		ctl.vol_write = (state_q == S_WRITE);
		ctl.out_load  = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces one leaving in the same cycle
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= stat.vol_needed ? S_MUL : S_DONE;
				end
				S_MUL: begin
					state_q <= S_DIV;
					step_q  <= '0;
				end
				S_DIV: begin
					if (step_q == fpt_pkg::DIV_CNT_W'(fpt_pkg::DIV_STEPS - 1)) begin
						state_q <= S_WRITE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/fpt_dpath.sv
// ----------------------------------------------------------------------------
// fpt_dpath
// Channel state, configuration registers, millisecond clock, volume
// multiply and a bit-serial restoring divider, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [fpt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fpt_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  wire logic [fpt_pkg::CMD_W-1:0]       item_cmd,
	input  wire logic [fpt_pkg::CH_W-1:0]        item_channel,
	input  wire fpt_pkg::fpt_cmd_t               ctl,
	output fpt_pkg::fpt_stat_t                   stat,
	output logic [fpt_pkg::CH_W-1:0]             out_channel,
	output logic [fpt_pkg::CNT_W-1:0]            pulse_total,
	output logic [fpt_pkg::CNT_W-1:0]            volume_ml,
	output logic                                 started,
	output logic                                 timed_out
);

	// configuration
	logic [fpt_pkg::CAL_W-1:0] cal_q   [fpt_pkg::CH_SLOTS];
	logic [fpt_pkg::CNT_W-1:0] limit_q [fpt_pkg::CH_SLOTS];

	// channel state
	logic [fpt_pkg::CNT_W-1:0] pulse_q  [fpt_pkg::CH_SLOTS];
	logic [fpt_pkg::CNT_W-1:0] volume_q [fpt_pkg::CH_SLOTS];
	logic [fpt_pkg::CNT_W-1:0] stamp_q  [fpt_pkg::CH_SLOTS];
	logic [fpt_pkg::CH_SLOTS-1:0] start_valid_q;
	logic [fpt_pkg::CNT_W-1:0] now_ms_q;

	// latched item
	logic [fpt_pkg::CMD_W-1:0] cmd_q;
	logic [fpt_pkg::CH_W-1:0]  ch_q;
	logic                      present;

	// divider
	logic [fpt_pkg::NUM_W-1:0] div_quo_q;
	logic [fpt_pkg::DEN_W-1:0] div_den_q;
	logic [fpt_pkg::DEN_W-1:0] div_rem_q;
	logic [fpt_pkg::DEN_W:0]   trial;
	logic [fpt_pkg::DEN_W:0]   diff;
	logic                      trial_ge;
	logic [fpt_pkg::CNT_W-1:0] vol_sat;

	// result register
	logic [fpt_pkg::CH_W-1:0]  out_channel_q;
	logic [fpt_pkg::CNT_W-1:0] pulse_total_q;
	logic [fpt_pkg::CNT_W-1:0] volume_ml_q;
	logic                      started_q;
	logic                      timed_out_q;
	logic [fpt_pkg::CNT_W-1:0] elapsed;

	assign present = ({1'b0, ch_q} < (fpt_pkg::CH_W + 1)'(fpt_pkg::CHANNELS));
	assign stat.vol_needed = present && (cmd_q == fpt_pkg::CMD_PULSE);

	assign trial    = {div_rem_q, div_quo_q[fpt_pkg::NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, div_den_q});
	assign diff     = trial - {1'b0, div_den_q};
	// quotient beyond 32 bits saturates; a zero divisor yields all ones
	assign vol_sat  = (|div_quo_q[fpt_pkg::NUM_W-1:fpt_pkg::CNT_W]) ? '1 :
	                  div_quo_q[fpt_pkg::CNT_W-1:0];

	assign elapsed  = now_ms_q - stamp_q[ch_q];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpt_pkg::CH_SLOTS; i++) begin
				cal_q[i]   <= fpt_pkg::CAL_RESET;
				limit_q[i] <= fpt_pkg::LIMIT_RESET;
			end
		end else if (cfg_write) begin
			if (cfg_index < fpt_pkg::REG_LIMIT_BASE) begin
				cal_q[cfg_index[fpt_pkg::CH_W-1:0]] <= cfg_data[fpt_pkg::CAL_W-1:0];
			end else if (cfg_index < fpt_pkg::REG_END) begin
				limit_q[cfg_index[fpt_pkg::CH_W-1:0]] <= cfg_data[fpt_pkg::CNT_W-1:0];
			end
		end
	end

	// channel state and clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpt_pkg::CH_SLOTS; i++) begin
				pulse_q[i]  <= '0;
				volume_q[i] <= '0;
				stamp_q[i]  <= '0;
			end
			start_valid_q <= '0;
			now_ms_q      <= '0;
			cmd_q         <= fpt_pkg::CMD_QUERY;
			ch_q          <= '0;
		end else begin
			if (ctl.item_load) begin
				cmd_q <= item_cmd;
				ch_q  <= item_channel;
			end
			if (ctl.apply) begin
				if (cmd_q == fpt_pkg::CMD_TICK) begin
					now_ms_q <= now_ms_q + 1'b1;
				end else if (present) begin
					case (cmd_q)
						fpt_pkg::CMD_PULSE: begin
							if (!start_valid_q[ch_q]) begin
								stamp_q[ch_q]       <= now_ms_q;
								start_valid_q[ch_q] <= 1'b1;
							end
							if (pulse_q[ch_q] != '1) begin
								pulse_q[ch_q] <= pulse_q[ch_q] + 1'b1;
							end
						end
						fpt_pkg::CMD_CLEAR: begin
							pulse_q[ch_q]       <= '0;
							volume_q[ch_q]      <= '0;
							stamp_q[ch_q]       <= '0;
							start_valid_q[ch_q] <= 1'b0;
						end
						fpt_pkg::CMD_MARK: begin
							stamp_q[ch_q]       <= now_ms_q;
							start_valid_q[ch_q] <= 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			if (ctl.vol_write) begin
				volume_q[ch_q] <= vol_sat;
			end
		end
	end

	// numerator/divisor set-up and one quotient bit per step, MSB first
	always_ff @(posedge clk) begin
		if (ctl.mul_load) begin
			div_quo_q <= fpt_pkg::NUM_W'(pulse_q[ch_q]) * fpt_pkg::NUM_W'(fpt_pkg::VOL_NUM);
			div_den_q <= fpt_pkg::DEN_W'(cal_q[ch_q]) * fpt_pkg::DEN_W'(fpt_pkg::DEN_MUL);
			div_rem_q <= '0;
		end else if (ctl.div_step) begin
			div_rem_q <= trial_ge ? diff[fpt_pkg::DEN_W-1:0] : trial[fpt_pkg::DEN_W-1:0];
			div_quo_q <= {div_quo_q[fpt_pkg::NUM_W-2:0], trial_ge};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_channel_q <= ch_q;
			if (present) begin
				pulse_total_q <= pulse_q[ch_q];
				volume_ml_q   <= volume_q[ch_q];
				started_q     <= start_valid_q[ch_q];
				timed_out_q   <= start_valid_q[ch_q] && (elapsed >= limit_q[ch_q]);
			end else begin
				pulse_total_q <= '0;
				volume_ml_q   <= '0;
				started_q     <= 1'b0;
				timed_out_q   <= 1'b0;
			end
		end
	end

	assign out_channel = out_channel_q;
	assign pulse_total = pulse_total_q;
	assign volume_ml   = volume_ml_q;
	assign started     = started_q;
	assign timed_out   = timed_out_q;

endmodule

`default_nettype wire

>>> rtl/flow_pulse_totalizer_unit.sv
// ----------------------------------------------------------------------------
// flow_pulse_totalizer_unit
// Four-channel flow sensor pulse totaliser with per-channel volume and
// watering timeout status.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one beat carries cmd and channel.
//    Commands: pulse, millisecond tick, clear, mark start, query (codes 5..7
//    behave as query). Every beat yields exactly one status beat.
//  - Output channel (out_valid/out_ready): out_channel echoes the channel,
//    with its pulse total, stored volume in ml, started and timed-out flags.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): indexes 0..3
//    are the Q4 calibration factors, 4..7 the timeout limits in ms; other
//    indexes are ignored. cfg_ready is always high; write only when idle.
//  - Sequence: a pulse passes update, numerator set-up, the restoring
//    divider retiring one of 42 quotient bits per cycle and the volume write
//    before out_valid; other commands skip the divider. One item is in flight
//    at a time: a beat is taken once the last result is in the output register.
//  - A stalled receiver holds the result in the output register; the block
//    still takes the next beat and parks its result until the slot frees.
//  - Reset: calibration factors 120 (7.5 in Q4), limits 10 ms, all counts,
//    volumes, stamps, started flags and the ms clock cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_pulse_totalizer_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// item channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [fpt_pkg::CMD_W-1:0]       cmd,
	input  wire logic [fpt_pkg::CH_W-1:0]        channel,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [fpt_pkg::CH_W-1:0]             out_channel,
	output logic [fpt_pkg::CNT_W-1:0]            pulse_total,
	output logic [fpt_pkg::CNT_W-1:0]            volume_ml,
	output logic                                 started,
	output logic                                 timed_out,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fpt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fpt_pkg::CFG_DAT_W-1:0]   cfg_data
);

	fpt_pkg::fpt_cmd_t  ctl;
	fpt_pkg::fpt_stat_t stat;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	fpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.stat      (stat)
	);

	fpt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_cmd     (cmd),
		.item_channel (channel),
		.ctl          (ctl),
		.stat         (stat),
		.out_channel  (out_channel),
		.pulse_total  (pulse_total),
		.volume_ml    (volume_ml),
		.started      (started),
		.timed_out    (timed_out)
	);

endmodule

`default_nettype wire

>>> rtl/fpt_checker.sv
// ----------------------------------------------------------------------------
// fpt_checker
// Port-level checks of the flow pulse totaliser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpt_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [fpt_pkg::CH_W-1:0]        out_channel,
	input wire logic [fpt_pkg::CNT_W-1:0]       pulse_total,
	input wire logic [fpt_pkg::CNT_W-1:0]       volume_ml,
	input wire logic                            started,
	input wire logic                            timed_out
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
		$stable(pulse_total) && $stable(volume_ml) && $stable(started) &&
		$stable(timed_out))
		else $error("result beat changed while stalled");

	// one item at a time: no beat taken in the cycle after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in progress");

	// timeout only ever reported for a started channel
	a_timeout_started: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !timed_out || started)
		else $error("timed_out without started");

	// pulses always start a channel, clear zeroes everything
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !started |-> pulse_total == '0 && volume_ml == '0)
		else $error("unstarted channel reports pulses or volume");

endmodule

bind flow_pulse_totalizer_unit fpt_checker u_fpt_checker (.*);

`default_nettype wire
